[rtl/bmrm_pkg.sv]
package bmrm_pkg;

    // Largest map side supported; the map memory holds MAX_DIM * MAX_DIM cells.
    localparam int MAX_DIM = 32;

    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;
    localparam int DIM_W     = $clog2(MAX_DIM + 1);
    localparam int POS_W     = $clog2(MAX_DIM);
    localparam int MAP_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W    = $clog2(MAP_DEPTH);
    localparam int LIN_W     = $clog2(MAP_DEPTH + 1);
    localparam int AREA_W    = $clog2(MAP_DEPTH + 1);
    localparam int KIND_W    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COLS = CFG_IDX_W'(1);

    localparam logic [KIND_W-1:0] KIND_WIDEST  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TALLEST = 2'd1;
    localparam logic [KIND_W-1:0] KIND_AREA    = 2'd2;

    // Output word layout, lowest bit first.
    localparam int W_LSB       = 0;
    localparam int H_LSB       = W_LSB + DIM_W;
    localparam int A_LSB       = H_LSB + DIM_W;
    localparam int T_LSB       = A_LSB + AREA_W;
    localparam int L_LSB       = T_LSB + POS_W;
    localparam int OUT_BITS    = L_LSB + POS_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TUSER_W = KIND_W + 1;
    localparam int FOUND_BIT   = KIND_W;

    typedef enum logic [3:0] {
        S_LOAD,
        S_CELL_RD,
        S_CELL_CHK,
        S_WID_RD,
        S_WID_CHK,
        S_HGT_RD,
        S_HGT_CHK,
        S_MUL,
        S_UPD,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic              found;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [AREA_W-1:0] area;
        logic [POS_W-1:0]  top_row;
        logic [POS_W-1:0]  left_col;
    } rec_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0)
        begin
            res = DIM_W'(1);
        end
        else if (int'(v) > MAX_DIM)
        begin
            res = DIM_W'(MAX_DIM);
        end
        else
        begin
            res = DIM_W'(v);
        end
        return res;
    endfunction

endpackage

[rtl/bmrm_ram.sv]
// Simple dual-port RAM: one write port, one read port with registered data.
module bmrm_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 1
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/binary_map_rectangle_measure.sv]
// Binary map rectangle measure. Pixels stream in on the slave side one word per
// cycle in row-major order and are written to a single-bit map memory; pixels
// beyond rows_in_use * cols_in_use are dropped. The word with tlast set starts a
// scan. The scan walks each row; at every set pixel it measures the run of ones
// to the right (width) and the run of ones downward (height), forms the area, and
// updates three records (widest, tallest, largest area, earliest wins ties). It
// then skips past the measured run. When the scan is done three result words
// leave on the master side: widest, tallest, largest area, the last with tlast.
// The scan reads the map through the memory's single read port, giving
// an address and then taking registered data back. It reads each cell that
// the scan stops at, each extra column of a width run and each extra row of
// a height run, plus the clear cell that ends a run short of the map edge;
// a run that reaches the edge gets a bound check instead of a read. Each set
// pixel measured then goes through a multiply and a record update, the scan
// steps down to the next row at the end of each row, and a final row check
// ends the scan and moves on to the output. The three result words follow at one
// per cycle when the sink is ready. Input is not taken during the scan or while
// results are still being handed out; the last result may still be waiting in
// the output register while the next map loads. Configuration writes are always
// accepted and must only happen while the block is idle. Cells never loaded for
// the current map read as zero.
module binary_map_rectangle_measure (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write channel.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bmrm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bmrm_pkg::CFG_W-1:0]           cfg_data,
    // Pixel input. s_tdata: [0] pixel, rest zero. s_tlast: last_pixel.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [bmrm_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                 s_tlast,
    // Result output. m_tdata: [5:0] width, [11:6] height, [22:12] area,
    // [27:23] top_row, [32:28] left_col, rest zero.
    // m_tuser: [1:0] record_kind, [2] found. m_tlast: last_record.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [bmrm_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic [bmrm_pkg::OUT_TUSER_W-1:0]     m_tuser,
    output logic                                 m_tlast
);

    localparam int DIM_W  = bmrm_pkg::DIM_W;
    localparam int LIN_W  = bmrm_pkg::LIN_W;
    localparam int AREA_W = bmrm_pkg::AREA_W;
    localparam int POS_W  = bmrm_pkg::POS_W;
    localparam int KIND_W = bmrm_pkg::KIND_W;

    bmrm_pkg::state_t state_reg, state_next;

    logic [bmrm_pkg::CFG_W-1:0] rows_cfg_reg, cols_cfg_reg;
    logic [DIM_W-1:0]           rows_eff, cols_eff;
    logic [LIN_W-1:0]           total;
    logic [LIN_W-1:0]           load_pos_reg;

    logic                       s_accept;
    logic                       ram_we;
    logic                       ram_re;
    logic [LIN_W-1:0]           rd_addr_lin;
    logic [0:0]                 ram_rdata;
    logic                       rd_ok_reg;
    logic                       cell_bit;

    // Scan cursor and measurement registers.
    logic [DIM_W-1:0]           r_reg, c_reg, x_reg, y_reg;
    logic [DIM_W-1:0]           w_reg, h_reg;
    logic [LIN_W-1:0]           base_reg, yaddr_reg;
    logic [AREA_W-1:0]          area_reg;
    logic [AREA_W-1:0]          vals [3];

    bmrm_pkg::rec_t             rec_reg [3];
    logic [AREA_W-1:0]          best_reg [3];

    logic [KIND_W-1:0]          k_reg;
    logic                       out_load;
    logic                       m_tvalid_reg;
    logic [bmrm_pkg::OUT_TDATA_W-1:0] m_tdata_reg;
    logic [bmrm_pkg::OUT_TUSER_W-1:0] m_tuser_reg;
    logic                       m_tlast_reg;

    assign cfg_ready = 1'b1;
    assign rows_eff  = bmrm_pkg::clamp_dim(rows_cfg_reg);
    assign cols_eff  = bmrm_pkg::clamp_dim(cols_cfg_reg);
    assign total     = LIN_W'(rows_eff) * LIN_W'(cols_eff);
    assign s_accept  = s_tvalid && s_tready;
    assign ram_we    = s_accept && (load_pos_reg < total);
    assign cell_bit  = ram_rdata[0] && rd_ok_reg;

    assign vals[0] = AREA_W'(w_reg);
    assign vals[1] = AREA_W'(h_reg);
    assign vals[2] = area_reg;

    bmrm_ram #(
        .DEPTH(bmrm_pkg::MAP_DEPTH),
        .WIDTH(1)
    ) u_map (
        .clk  (clk),
        .we   (ram_we),
        .waddr(load_pos_reg[bmrm_pkg::ADDR_W-1:0]),
        .wdata(s_tdata[0:0]),
        .re   (ram_re),
        .raddr(rd_addr_lin[bmrm_pkg::ADDR_W-1:0]),
        .rdata(ram_rdata)
    );

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bmrm_pkg::S_LOAD:
            begin
                if (s_accept && s_tlast)
                begin
                    state_next = bmrm_pkg::S_CELL_RD;
                end
            end
            bmrm_pkg::S_CELL_RD:
            begin
                if (r_reg == rows_eff)
                begin
                    state_next = bmrm_pkg::S_EMIT;
                end
                else if (c_reg != cols_eff)
                begin
                    state_next = bmrm_pkg::S_CELL_CHK;
                end
            end
            bmrm_pkg::S_CELL_CHK:
            begin
                state_next = cell_bit ? bmrm_pkg::S_WID_RD : bmrm_pkg::S_CELL_RD;
            end
            bmrm_pkg::S_WID_RD:
            begin
                state_next = (x_reg == cols_eff) ? bmrm_pkg::S_HGT_RD : bmrm_pkg::S_WID_CHK;
            end
            bmrm_pkg::S_WID_CHK:
            begin
                state_next = cell_bit ? bmrm_pkg::S_WID_RD : bmrm_pkg::S_HGT_RD;
            end
            bmrm_pkg::S_HGT_RD:
            begin
                state_next = (y_reg == rows_eff) ? bmrm_pkg::S_MUL : bmrm_pkg::S_HGT_CHK;
            end
            bmrm_pkg::S_HGT_CHK:
            begin
                state_next = cell_bit ? bmrm_pkg::S_HGT_RD : bmrm_pkg::S_MUL;
            end
            bmrm_pkg::S_MUL:
            begin
                state_next = bmrm_pkg::S_UPD;
            end
            bmrm_pkg::S_UPD:
            begin
                state_next = bmrm_pkg::S_CELL_RD;
            end
            bmrm_pkg::S_EMIT:
            begin
                if (out_load && (k_reg == bmrm_pkg::KIND_AREA))
                begin
                    state_next = bmrm_pkg::S_LOAD;
                end
            end
            default:
            begin
                state_next = bmrm_pkg::S_LOAD;
            end
        endcase
    end

    // Outputs of the state machine: handshake and map read port.
    always_comb
    begin
        s_tready    = 1'b0;
        ram_re      = 1'b0;
        rd_addr_lin = base_reg + LIN_W'(c_reg);
        out_load    = 1'b0;
        unique case (state_reg)
            bmrm_pkg::S_LOAD:
            begin
                s_tready = 1'b1;
            end
            bmrm_pkg::S_CELL_RD:
            begin
                ram_re = (r_reg != rows_eff) && (c_reg != cols_eff);
            end
            bmrm_pkg::S_WID_RD:
            begin
                ram_re      = (x_reg != cols_eff);
                rd_addr_lin = base_reg + LIN_W'(x_reg);
            end
            bmrm_pkg::S_HGT_RD:
            begin
                ram_re      = (y_reg != rows_eff);
                rd_addr_lin = yaddr_reg;
            end
            bmrm_pkg::S_EMIT:
            begin
                out_load = !m_tvalid_reg || m_tready;
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
    end

    // Control state, configuration, records and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bmrm_pkg::S_LOAD;
            rows_cfg_reg <= bmrm_pkg::CFG_W'(32);
            cols_cfg_reg <= bmrm_pkg::CFG_W'(32);
            load_pos_reg <= '0;
            k_reg        <= bmrm_pkg::KIND_WIDEST;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                rec_reg[i]  <= '0;
                best_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    bmrm_pkg::REG_ROWS: rows_cfg_reg <= cfg_data;
                    bmrm_pkg::REG_COLS: cols_cfg_reg <= cfg_data;
                    default:            rows_cfg_reg <= rows_cfg_reg;
                endcase
            end

            if (ram_we)
            begin
                load_pos_reg <= load_pos_reg + LIN_W'(1);
            end

            if (state_reg == bmrm_pkg::S_UPD)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (vals[i] > best_reg[i])
                    begin
                        best_reg[i]         <= vals[i];
                        rec_reg[i].found    <= 1'b1;
                        rec_reg[i].width    <= w_reg;
                        rec_reg[i].height   <= h_reg;
                        rec_reg[i].area     <= area_reg;
                        rec_reg[i].top_row  <= POS_W'(r_reg);
                        rec_reg[i].left_col <= POS_W'(c_reg);
                    end
                end
            end

            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
                if (k_reg == bmrm_pkg::KIND_AREA)
                begin
                    // Map handed out: ready for the next one.
                    k_reg        <= bmrm_pkg::KIND_WIDEST;
                    load_pos_reg <= '0;
                    for (int i = 0; i < 3; i++)
                    begin
                        rec_reg[i]  <= '0;
                        best_reg[i] <= '0;
                    end
                end
                else
                begin
                    k_reg <= k_reg + KIND_W'(1);
                end
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Scan datapath and output payload; no reset needed.
    always_ff @(posedge clk)
    begin
        rd_ok_reg <= (rd_addr_lin < load_pos_reg);

        unique case (state_reg)
            bmrm_pkg::S_LOAD:
            begin
                r_reg    <= '0;
                c_reg    <= '0;
                base_reg <= '0;
            end
            bmrm_pkg::S_CELL_RD:
            begin
                if ((r_reg != rows_eff) && (c_reg == cols_eff))
                begin
                    r_reg    <= r_reg + DIM_W'(1);
                    c_reg    <= '0;
                    base_reg <= base_reg + LIN_W'(cols_eff);
                end
            end
            bmrm_pkg::S_CELL_CHK:
            begin
                if (cell_bit)
                begin
                    w_reg     <= DIM_W'(1);
                    x_reg     <= c_reg + DIM_W'(1);
                    h_reg     <= DIM_W'(1);
                    y_reg     <= r_reg + DIM_W'(1);
                    yaddr_reg <= base_reg + LIN_W'(c_reg) + LIN_W'(cols_eff);
                end
                else
                begin
                    c_reg <= c_reg + DIM_W'(1);
                end
            end
            bmrm_pkg::S_WID_CHK:
            begin
                if (cell_bit)
                begin
                    w_reg <= w_reg + DIM_W'(1);
                    x_reg <= x_reg + DIM_W'(1);
                end
            end
            bmrm_pkg::S_HGT_CHK:
            begin
                if (cell_bit)
                begin
                    h_reg     <= h_reg + DIM_W'(1);
                    y_reg     <= y_reg + DIM_W'(1);
                    yaddr_reg <= yaddr_reg + LIN_W'(cols_eff);
                end
            end
            bmrm_pkg::S_MUL:
            begin
                area_reg <= AREA_W'(w_reg) * AREA_W'(h_reg);
            end
            bmrm_pkg::S_UPD:
            begin
                // Resume the scan after the measured run.
                c_reg <= c_reg + w_reg;
            end
            default:
            begin
                area_reg <= area_reg;
            end
        endcase

        if (out_load)
        begin
            // Fields from the lowest bit up: width, height, area, top_row, left_col.
            m_tdata_reg <= bmrm_pkg::OUT_TDATA_W'({rec_reg[k_reg].left_col,
                                                   rec_reg[k_reg].top_row,
                                                   rec_reg[k_reg].area,
                                                   rec_reg[k_reg].height,
                                                   rec_reg[k_reg].width});
            m_tuser_reg <= {rec_reg[k_reg].found, k_reg};
            m_tlast_reg <= (k_reg == bmrm_pkg::KIND_AREA);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

[rtl/bmrm_checker.sv]
// Port-level checks on the result stream of the rectangle measure block.
module bmrm_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_tready,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [bmrm_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input logic [bmrm_pkg::OUT_TUSER_W-1:0]     m_tuser,
    input logic                                 m_tlast
);

    // The area word always equals width times height.
    a_area: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[bmrm_pkg::A_LSB +: bmrm_pkg::AREA_W] ==
            bmrm_pkg::AREA_W'(m_tdata[bmrm_pkg::W_LSB +: bmrm_pkg::DIM_W]) *
            bmrm_pkg::AREA_W'(m_tdata[bmrm_pkg::H_LSB +: bmrm_pkg::DIM_W])))
        else $error("area does not match width times height");

    // A record without a set pixel carries an all-zero word.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[bmrm_pkg::FOUND_BIT]) |-> (m_tdata == '0))
        else $error("empty record with nonzero data");

    // tlast marks exactly the largest-area record.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser[bmrm_pkg::KIND_W-1:0] == bmrm_pkg::KIND_AREA)))
        else $error("tlast not on the area record");

    // Once a non-final record is taken, the next one follows at once.
    a_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("record set interrupted");

    // No pixel is taken while the remaining records of a set are still pending.
    a_no_load: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && (m_tuser[bmrm_pkg::KIND_W-1:0] == bmrm_pkg::KIND_WIDEST))
        |=> !s_tready)
        else $error("input taken during result hand-out");

endmodule

bind binary_map_rectangle_measure bmrm_checker u_bmrm_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
);

[sim/rectangle_record_checker.sv]
`timescale 1ns / 1ps

// Watches the configuration, pixel and result channels of the rectangle measure
// block. It keeps its own copy of the map and the dimension registers, works out
// the three records for every map, and compares each result word against them.
module rectangle_record_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [bmrm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bmrm_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic [bmrm_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                 s_tlast,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [bmrm_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic [bmrm_pkg::OUT_TUSER_W-1:0]     m_tuser,
    input  logic                                 m_tlast,
    output int                                   mismatches,
    output int                                   outstanding
);

    localparam int CFG_W     = bmrm_pkg::CFG_W;
    localparam int KIND_W    = bmrm_pkg::KIND_W;
    localparam int DIM_W     = bmrm_pkg::DIM_W;
    localparam int AREA_W    = bmrm_pkg::AREA_W;
    localparam int POS_W     = bmrm_pkg::POS_W;
    localparam int MAX_DIM   = bmrm_pkg::MAX_DIM;
    localparam int MAP_DEPTH = bmrm_pkg::MAP_DEPTH;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              found;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [AREA_W-1:0] area;
        logic [POS_W-1:0]  top_row;
        logic [POS_W-1:0]  left_col;
        logic              last_rec;
    } rect_result_t;

    logic         map_cells [MAP_DEPTH];
    int           fill_count;
    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] cols_reg;
    rect_result_t expected_records [$];
    int           errors;

    function automatic int effective_dim(input logic [CFG_W-1:0] v);
        if (v == '0)
        begin
            return 1;
        end
        if (int'(v) > MAX_DIM)
        begin
            return MAX_DIM;
        end
        return int'(v);
    endfunction

    // Cells past the number loaded for this map read as background.
    function automatic logic map_bit(input int r, input int c, input int col_count);
        int idx;
        idx = r * col_count + c;
        if (idx >= fill_count)
        begin
            return 1'b0;
        end
        return map_cells[idx];
    endfunction

    task automatic measure_map();
        int           row_count;
        int           col_count;
        int           r;
        int           c;
        int           x;
        int           w;
        int           h;
        int           a;
        int           vals [3];
        int           best_val [3];
        rect_result_t best [3];
        row_count = effective_dim(rows_reg);
        col_count = effective_dim(cols_reg);
        for (int k = 0; k < 3; k++)
        begin
            best[k] = '0;
            best_val[k] = 0;
        end
        best[0].kind = bmrm_pkg::KIND_WIDEST;
        best[1].kind = bmrm_pkg::KIND_TALLEST;
        best[2].kind = bmrm_pkg::KIND_AREA;
        best[2].last_rec = 1'b1;
        for (r = 0; r < row_count; r++)
        begin
            c = 0;
            while (c < col_count)
            begin
                if (map_bit(r, c, col_count))
                begin
                    w = 1;
                    h = 1;
                    for (x = c + 1; x < col_count && map_bit(r, x, col_count); x++)
                    begin
                        w++;
                    end
                    for (x = r + 1; x < row_count && map_bit(x, c, col_count); x++)
                    begin
                        h++;
                    end
                    a = w * h;
                    vals[0] = w;
                    vals[1] = h;
                    vals[2] = a;
                    // Strictly greater, so the first rectangle found keeps a tie.
                    for (int k = 0; k < 3; k++)
                    begin
                        if (vals[k] > best_val[k])
                        begin
                            best_val[k]      = vals[k];
                            best[k].found    = 1'b1;
                            best[k].width    = DIM_W'(w);
                            best[k].height   = DIM_W'(h);
                            best[k].area     = AREA_W'(a);
                            best[k].top_row  = POS_W'(r);
                            best[k].left_col = POS_W'(c);
                        end
                    end
                    c += w;
                end
                else
                begin
                    c++;
                end
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            expected_records.push_back(best[k]);
        end
        fill_count = 0;
    endtask

    task automatic take_pixel(input logic pixel, input logic last_mark);
        if (fill_count < effective_dim(rows_reg) * effective_dim(cols_reg))
        begin
            map_cells[fill_count] = pixel;
            fill_count++;
        end
        if (last_mark)
        begin
            measure_map();
        end
    endtask

    task automatic compare_field(input string field_name, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, field_name, want_v, got_v);
        end
    endtask

    task automatic check_result();
        rect_result_t want;
        if (expected_records.size() == 0)
        begin
            errors++;
            $display("%0t: result word with none expected, expected nothing actual tuser %0h tdata %0h",
                     $time, m_tuser, m_tdata);
        end
        else
        begin
            want = expected_records.pop_front();
            compare_field("record_kind", want.kind, m_tuser[KIND_W-1:0]);
            compare_field("found", want.found, m_tuser[bmrm_pkg::FOUND_BIT]);
            compare_field("width", want.width, m_tdata[bmrm_pkg::W_LSB +: DIM_W]);
            compare_field("height", want.height, m_tdata[bmrm_pkg::H_LSB +: DIM_W]);
            compare_field("area", want.area, m_tdata[bmrm_pkg::A_LSB +: AREA_W]);
            compare_field("top_row", want.top_row, m_tdata[bmrm_pkg::T_LSB +: POS_W]);
            compare_field("left_col", want.left_col, m_tdata[bmrm_pkg::L_LSB +: POS_W]);
            compare_field("last_record", want.last_rec, m_tlast);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg = CFG_W'(MAX_DIM);
            cols_reg = CFG_W'(MAX_DIM);
            fill_count = 0;
            expected_records.delete();
            errors = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bmrm_pkg::REG_ROWS: rows_reg = cfg_data;
                    bmrm_pkg::REG_COLS: cols_reg = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                check_result();
            end
            if (s_tvalid && s_tready)
            begin
                take_pixel(s_tdata[0], s_tlast);
            end
            mismatches  <= errors;
            outstanding <= expected_records.size();
        end
    end

endmodule

[sim/binary_map_rectangle_measure_test.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the rectangle measure block. Maps are streamed in as
// one pixel word per handshake; the checker beside the block predicts the three
// record words of every map and counts mismatches.
module binary_map_rectangle_measure_test;

    localparam int CFG_IDX_W   = bmrm_pkg::CFG_IDX_W;
    localparam int CFG_W       = bmrm_pkg::CFG_W;
    localparam int IN_TDATA_W  = bmrm_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = bmrm_pkg::OUT_TDATA_W;
    localparam int OUT_TUSER_W = bmrm_pkg::OUT_TUSER_W;
    localparam int MAX_DIM     = bmrm_pkg::MAX_DIM;

    // Watchdog bound on the length of the whole run, in clock cycles.
    localparam int LIMIT_CYCLES  = 400000;
    // Quiet cycles after the last record word before the dimensions may change.
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_WORDS  = 190;
    // Columns of the full-height directed map.
    localparam int TALL_COLS     = 4;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = bmrm_pkg::REG_ROWS;
    logic [CFG_W-1:0]       cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tlast   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   m_tlast;

    int mismatches;
    int outstanding;
    int cycle_count     = 0;
    bit sender_gaps_on  = 1'b1;
    bit sink_steady     = 1'b0;
    int fed_words;

    binary_map_rectangle_measure u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    rectangle_record_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result sink. It alternates between long stretches of always being ready and
    // stretches of random back-pressure, mostly short stalls with a few long ones.
    initial
    begin
        int hold;
        int pick;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
            end
            else
            begin
                if ($urandom_range(0, 199) == 0)
                begin
                    sink_steady = !sink_steady;
                end
                pick = $urandom_range(0, 99);
                if (sink_steady || pick < 60)
                begin
                    m_tready <= 1'b1;
                end
                else if (pick < 95)
                begin
                    m_tready <= 1'b0;
                    hold = $urandom_range(0, 3);
                end
                else
                begin
                    m_tready <= 1'b0;
                    hold = $urandom_range(10, 40);
                end
            end
        end
    end

    // Gap in cycles before the next pixel word; zero when the sender runs flat out.
    function automatic int sender_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (!sender_gaps_on || pick < 70)
        begin
            return 0;
        end
        if (pick < 95)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic int effective_dim(input logic [CFG_W-1:0] v);
        if (v == '0)
        begin
            return 1;
        end
        if (int'(v) > MAX_DIM)
        begin
            return MAX_DIM;
        end
        return int'(v);
    endfunction

    // Sends one pixel word and returns in the time step of its handshake. The
    // valid is only lowered when a gap follows, so back-to-back words keep it high.
    task automatic push_word(input logic pixel, input logic last_mark);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'(pixel);
        s_tlast  <= last_mark;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    // A hand-written map, pixel 0 in bit 0; the final word carries the last mark.
    task automatic play_bits(input logic [63:0] bits, input int n_words);
        for (int i = 0; i < n_words; i++)
        begin
            push_word(bits[i], i == n_words - 1);
        end
        s_tvalid <= 1'b0;
    endtask

    // A random map where each pixel is set with the given percentage.
    task automatic play_random(input int n_words, input int density);
        for (int i = 0; i < n_words; i++)
        begin
            push_word($urandom_range(0, 99) < density, i == n_words - 1);
        end
        s_tvalid <= 1'b0;
    endtask

    // Waits for every predicted record word to come out, then lets the block settle.
    // The first edge lets the checker publish the records of the map just sent.
    task automatic wait_idle();
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes both dimension registers back to back with the valid held high.
    task automatic set_dims(input logic [CFG_W-1:0] rows_val, input logic [CFG_W-1:0] cols_val);
        cfg_valid <= 1'b1;
        cfg_index <= bmrm_pkg::REG_ROWS;
        cfg_data  <= rows_val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_index <= bmrm_pkg::REG_COLS;
        cfg_data  <= cols_val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [CFG_W-1:0] rows_val;
        logic [CFG_W-1:0] cols_val;
        int               total;
        int               n_words;
        int               density;
        int               pick;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed maps. Zero dimensions act as one: an empty single cell map
        // reports nothing found, then a single set cell.
        set_dims('0, '0);
        play_bits(64'b0, 1);
        wait_idle();
        play_bits(64'b1, 1);
        wait_idle();

        // Two by three: a wider run in the second row replaces the widest record,
        // then equal rectangles where the earliest must win the tie.
        set_dims(CFG_W'(2), CFG_W'(3));
        play_bits(64'b111011, 6);
        wait_idle();
        play_bits(64'b101101, 6);
        wait_idle();
        // Early last mark: the unloaded cells must read as background.
        play_bits(64'b11, 2);
        wait_idle();

        // One by two with two surplus pixels before the last mark; they are dropped.
        set_dims(CFG_W'(1), CFG_W'(2));
        play_bits(64'b1110, 4);
        wait_idle();

        // A full-height map, all set, for the tallest value the fields can hold
        // and the far rows; then an early last mark on the largest setting.
        set_dims(CFG_W'(MAX_DIM), CFG_W'(TALL_COLS));
        play_random(MAX_DIM * TALL_COLS, 100);
        wait_idle();
        set_dims(CFG_W'(MAX_DIM), '1);
        play_random(40, 60);
        wait_idle();

        // Random maps. Most are small and well formed; some are a single full
        // column or row for the far row and column positions, and a minority end
        // early or carry surplus pixels.
        fed_words = 0;
        while (fed_words < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                rows_val = CFG_W'($urandom_range(MAX_DIM, 63));
                cols_val = CFG_W'($urandom_range(0, 1));
            end
            else if (pick < 16)
            begin
                rows_val = CFG_W'($urandom_range(0, 1));
                cols_val = CFG_W'($urandom_range(MAX_DIM, 63));
            end
            else
            begin
                rows_val = CFG_W'($urandom_range(1, 6));
                cols_val = CFG_W'($urandom_range(1, 6));
            end
            set_dims(rows_val, cols_val);
            total = effective_dim(rows_val) * effective_dim(cols_val);

            case ($urandom_range(0, 3))
                0: density = 10;
                1: density = 50;
                2: density = 85;
                default: density = 100;
            endcase

            pick = $urandom_range(0, 9);
            if (pick == 7)
            begin
                n_words = $urandom_range(1, total);
            end
            else if (pick == 8)
            begin
                n_words = total + $urandom_range(1, 4);
            end
            else
            begin
                n_words = total;
            end

            sender_gaps_on = ($urandom_range(0, 3) != 0);
            play_random(n_words, density);
            fed_words += n_words;
            wait_idle();
        end

        if (mismatches == 0 && outstanding == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
